FILE: rtl/mlfq_task_scheduler_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the task scheduler core
// Concurrent assertion wrappers; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef MLFQ_TASK_SCHEDULER_CORE_ASSERT_SVH
`define MLFQ_TASK_SCHEDULER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Sizes, codes, task record type and queue pointer helpers.
// ----------------------------------------------------------------------------
package mlfq_pkg;

    localparam int MAX_TASKS  = 64;
    localparam int MAX_LEVELS = 4;
    localparam int NQ         = 4;   // quantum registers

    localparam int ID_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int LV_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int QA_W   = LV_W + ID_W;
    localparam int QDEPTH = 1 << QA_W;

    localparam logic [2:0] CFG_LEVELS   = 3'd0;
    localparam logic [2:0] CFG_QUANT0   = 3'd1;
    localparam logic [2:0] CFG_QUANT1   = 3'd2;
    localparam logic [2:0] CFG_QUANT2   = 3'd3;
    localparam logic [2:0] CFG_QUANT3   = 3'd4;
    localparam logic [2:0] CFG_CAPACITY = 3'd5;

    localparam logic       CMD_ARRIVE = 1'b0;
    localparam logic       CMD_TICK   = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ACTIVE = 2'd2;

    typedef struct packed {
        logic [15:0]     remaining;
        logic [15:0]     length;
        logic [15:0]     mem;
        logic [LV_W-1:0] level;
        logic [31:0]     arrival;
    } t_task;

    localparam int TASK_W = $bits(t_task);

    function automatic logic [ID_W-1:0] next_ptr(input logic [ID_W-1:0] p);
        logic [ID_W-1:0] r;
        if (int'(p) == MAX_TASKS - 1) r = '0;
        else                          r = p + 1'b1;
        return r;
    endfunction

    function automatic logic [ID_W-1:0] tail_ptr(input logic [ID_W-1:0]  head,
                                                 input logic [CNT_W-1:0] cnt);
        logic [ID_W+CNT_W:0] s;
        s = (ID_W+CNT_W+1)'(head) + (ID_W+CNT_W+1)'(cnt);
        if (s >= (ID_W+CNT_W+1)'(MAX_TASKS)) s = s - (ID_W+CNT_W+1)'(MAX_TASKS);
        return s[ID_W-1:0];
    endfunction

endpackage

FILE: rtl/mlfq_task_scheduler_core.sv
// ----------------------------------------------------------------------------
// mlfq_task_scheduler_core
// Multilevel feedback queue scheduler with memory pool admission.
// ----------------------------------------------------------------------------
// Each request is an arrive (register a task at level 0) or a tick (advance
// time one unit: preempt, dispatch, run, then finish or demote). One result
// per request. An arrive passes through S_ARRIVE; a tick passes through S_PRE,
// S_SEL and S_RUN, with S_QRD and S_TRD before S_RUN when a dispatch is tried,
// for the two chained registered reads (queue memory, then task table).
// S_ARRIVE and S_RUN hold while the result register is full and stalled.
// Task records live in one RAM (64 x 82), the level queues in another
// (4 levels x 64 slots); the running task's record is held in registers and
// written back when it is preempted or demoted. No clearing pass is needed.
module mlfq_task_scheduler_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_cmd,
    input  logic [mlfq_pkg::ID_W-1:0]   i_task_id,
    input  logic [15:0]                 i_run_length,
    input  logic [15:0]                 i_memory_need,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [31:0]                 o_time_now,
    output logic                        o_run_valid,
    output logic [mlfq_pkg::ID_W-1:0]   o_run_task,
    output logic                        o_first_start,
    output logic                        o_finished,
    output logic [31:0]                 o_turnaround,
    output logic [31:0]                 o_waiting,
    output logic                        o_demoted,
    output logic                        o_blocked,
    output logic [1:0]                  o_status,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_index,
    input  logic [15:0]                 i_cfg_data
);
    localparam int ID_W  = mlfq_pkg::ID_W;
    localparam int CNT_W = mlfq_pkg::CNT_W;
    localparam int LV_W  = mlfq_pkg::LV_W;
    localparam int QA_W  = mlfq_pkg::QA_W;
    localparam int NL    = mlfq_pkg::MAX_LEVELS;
    localparam int NT    = mlfq_pkg::MAX_TASKS;

    typedef enum logic [2:0] {
        S_IDLE, S_ARRIVE, S_PRE, S_SEL, S_QRD, S_TRD, S_RUN
    } t_state;

    t_state r_state;

    // config
    logic [2:0]  r_levels;
    logic [7:0]  r_quant [mlfq_pkg::NQ];
    logic [15:0] r_cap;

    // scheduler state
    logic [15:0]      r_free;
    logic [31:0]      r_tick;
    logic [ID_W-1:0]  r_head [NL];
    logic [CNT_W-1:0] r_cnt  [NL];
    logic [NT-1:0]    r_present;
    logic [NT-1:0]    r_started;
    logic             r_act_valid;
    logic [ID_W-1:0]  r_act_id;
    mlfq_pkg::t_task  r_act;
    logic [7:0]       r_qused;

    // per-request scratch
    logic [ID_W-1:0]  r_in_id;
    logic [15:0]      r_in_len;
    logic [15:0]      r_in_mem;
    logic [LV_W-1:0]  r_lv;
    logic [ID_W-1:0]  r_cand_id;
    logic             r_blocked;
    logic             r_first;

    // result register
    logic             r_out_valid;
    logic [31:0]      r_time_now;
    logic             r_run_valid;
    logic [ID_W-1:0]  r_run_task;
    logic             r_first_start;
    logic             r_finished;
    logic [31:0]      r_turnaround;
    logic [31:0]      r_waiting;
    logic             r_demoted;
    logic             r_blocked_o;
    logic [1:0]       r_status;

    // memory ports
    logic                         task_we;
    logic [ID_W-1:0]              task_waddr;
    mlfq_pkg::t_task              task_wdata;
    mlfq_pkg::t_task              task_rdata;
    logic                         q_we;
    logic [QA_W-1:0]              q_waddr;
    logic [ID_W-1:0]              q_wdata;
    logic [QA_W-1:0]              q_raddr;
    logic [ID_W-1:0]              q_rdata;

    // combinational helpers
    logic             in_acc;
    logic             out_free;
    logic             sel_any;
    logic [LV_W-1:0]  sel_lv;
    logic             higher;
    logic [15:0]      gb_free;
    logic [16:0]      gb_sum;
    logic             arr_full;
    logic [15:0]      arr_len;
    logic [15:0]      rem_dec;
    logic [8:0]       qused_inc;
    logic [7:0]       qv;
    logic [1:0]       qidx;
    logic [LV_W-1:0]  dem_lv;
    logic [31:0]      tick_inc;
    logic [31:0]      ta;
    logic             run_fin;
    logic             run_dem;
    logic             fit;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // highest-priority non-empty level and preemption check
    always_comb begin
        sel_any = 1'b0;
        sel_lv  = '0;
        higher  = 1'b0;
        for (int lv = NL - 1; lv >= 0; lv--) begin
            if (r_cnt[lv] != '0) begin
                sel_any = 1'b1;
                sel_lv  = LV_W'(lv);
            end
        end
        for (int lv = 0; lv < NL; lv++) begin
            if (lv < int'(r_act.level) && r_cnt[lv] != '0) begin
                higher = 1'b1;
            end
        end
    end

    // release of the running task's memory, capped at the pool size
    assign gb_sum  = {1'b0, r_free} + {1'b0, r_act.mem};
    assign gb_free = (gb_sum > {1'b0, r_cap}) ? r_cap : gb_sum[15:0];

    assign arr_full = (r_cnt[0] >= CNT_W'(NT));
    assign arr_len  = (r_in_len == 16'd0) ? 16'd1 : r_in_len;
    assign fit      = !(r_free < task_rdata.mem);

    // run one unit
    always_comb begin
        int lvi;
        int eff;
        lvi       = int'(r_act.level);
        eff       = int'(r_levels);
        if (eff < 1)  eff = 1;
        if (eff > NL) eff = NL;
        qidx      = (lvi < 3) ? 2'(lvi) : 2'd3;
        qv        = (r_quant[qidx] == 8'd0) ? 8'd1 : r_quant[qidx];
        dem_lv    = (lvi + 1 < eff) ? LV_W'(lvi + 1) : r_act.level;
        rem_dec   = r_act.remaining - 16'd1;
        qused_inc = {1'b0, r_qused} + 9'd1;
        tick_inc  = r_tick + 32'd1;
        ta        = tick_inc - r_act.arrival;
        run_fin   = r_act_valid && (rem_dec == 16'd0);
        run_dem   = r_act_valid && !run_fin && (qused_inc >= {1'b0, qv});
    end

    // memory port control
    always_comb begin
        task_we    = 1'b0;
        task_waddr = r_act_id;
        task_wdata = r_act;
        q_we       = 1'b0;
        q_waddr    = {r_act.level, mlfq_pkg::tail_ptr(r_head[r_act.level], r_cnt[r_act.level])};
        q_wdata    = r_act_id;
        q_raddr    = {sel_lv, r_head[sel_lv]};
        case (r_state)
            S_ARRIVE: begin
                if (out_free && !r_present[r_in_id] && !arr_full) begin
                    task_we    = 1'b1;
                    task_waddr = r_in_id;
                    task_wdata = '{remaining: arr_len, length: arr_len, mem: r_in_mem,
                                   level: '0, arrival: r_tick};
                    q_we       = 1'b1;
                    q_waddr    = {LV_W'(0), mlfq_pkg::tail_ptr(r_head[0], r_cnt[0])};
                    q_wdata    = r_in_id;
                end
            end
            S_PRE: begin
                // preempted task back to the tail of its level
                if (r_act_valid && higher) begin
                    task_we = 1'b1;
                    q_we    = 1'b1;
                end
            end
            S_TRD: begin
                // refused for lack of memory: back to tail
                if (!fit) begin
                    q_we    = 1'b1;
                    q_waddr = {r_lv, mlfq_pkg::tail_ptr(r_head[r_lv], r_cnt[r_lv])};
                    q_wdata = r_cand_id;
                end
            end
            S_RUN: begin
                if (out_free && run_dem) begin
                    task_we          = 1'b1;
                    task_wdata.remaining = rem_dec;
                    task_wdata.level = dem_lv;
                    q_we             = 1'b1;
                    q_waddr          = {dem_lv,
                                        mlfq_pkg::tail_ptr(r_head[dem_lv], r_cnt[dem_lv])};
                end
            end
            default: begin
            end
        endcase
    end

    mlfq_ram #(.WIDTH(mlfq_pkg::TASK_W), .DEPTH(NT)) u_task_ram (
        .i_clk   (i_clk),
        .i_we    (task_we),
        .i_waddr (task_waddr),
        .i_wdata (task_wdata),
        .i_raddr (q_rdata),
        .o_rdata (task_rdata)
    );

    mlfq_ram #(.WIDTH(ID_W), .DEPTH(mlfq_pkg::QDEPTH)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    // sequencer, state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_levels    <= 3'd4;
            r_quant[0]  <= 8'd2;
            r_quant[1]  <= 8'd4;
            r_quant[2]  <= 8'd8;
            r_quant[3]  <= 8'd16;
            r_cap       <= 16'hFFFF;
            r_free      <= 16'hFFFF;
            r_tick      <= '0;
            for (int lv = 0; lv < NL; lv++) begin
                r_head[lv] <= '0;
                r_cnt[lv]  <= '0;
            end
            r_present   <= '0;
            r_started   <= '0;
            r_act_valid <= 1'b0;
            r_act_id    <= '0;
            r_qused     <= '0;
            r_out_valid <= 1'b0;
            r_blocked   <= 1'b0;
            r_first     <= 1'b0;
        end else begin
            // result taken; the load states set it again themselves
            if (r_out_valid && !i_out_stall && r_state != S_ARRIVE && r_state != S_RUN) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    mlfq_pkg::CFG_LEVELS:   r_levels   <= i_cfg_data[2:0];
                    mlfq_pkg::CFG_QUANT0:   r_quant[0] <= i_cfg_data[7:0];
                    mlfq_pkg::CFG_QUANT1:   r_quant[1] <= i_cfg_data[7:0];
                    mlfq_pkg::CFG_QUANT2:   r_quant[2] <= i_cfg_data[7:0];
                    mlfq_pkg::CFG_QUANT3:   r_quant[3] <= i_cfg_data[7:0];
                    mlfq_pkg::CFG_CAPACITY: begin
                        r_cap <= i_cfg_data;
                        if (r_act_valid) begin
                            r_free <= (i_cfg_data > r_act.mem) ? i_cfg_data - r_act.mem : '0;
                        end else begin
                            r_free <= i_cfg_data;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_in_id  <= i_task_id;
                        r_in_len <= i_run_length;
                        r_in_mem <= i_memory_need;
                        r_state  <= (i_cmd == mlfq_pkg::CMD_ARRIVE) ? S_ARRIVE : S_PRE;
                    end
                end
                S_ARRIVE: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_time_now    <= r_tick;
                        r_run_valid   <= 1'b0;
                        r_run_task    <= '0;
                        r_first_start <= 1'b0;
                        r_finished    <= 1'b0;
                        r_turnaround  <= '0;
                        r_waiting     <= '0;
                        r_demoted     <= 1'b0;
                        r_blocked_o   <= 1'b0;
                        if (r_present[r_in_id]) begin
                            r_status <= mlfq_pkg::ST_ACTIVE;
                        end else if (arr_full) begin
                            r_status <= mlfq_pkg::ST_FULL;
                        end else begin
                            r_status             <= mlfq_pkg::ST_OK;
                            r_cnt[0]             <= r_cnt[0] + 1'b1;
                            r_present[r_in_id]   <= 1'b1;
                            r_started[r_in_id]   <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_PRE: begin
                    r_blocked <= 1'b0;
                    r_first   <= 1'b0;
                    if (r_act_valid && higher) begin
                        r_free               <= gb_free;
                        r_cnt[r_act.level]   <= r_cnt[r_act.level] + 1'b1;
                        r_act_valid          <= 1'b0;
                        r_qused              <= '0;
                    end
                    r_state <= S_SEL;
                end
                S_SEL: begin
                    if (!r_act_valid && sel_any) begin
                        // pop the head; queue memory read issued this cycle
                        r_lv            <= sel_lv;
                        r_head[sel_lv]  <= mlfq_pkg::next_ptr(r_head[sel_lv]);
                        r_cnt[sel_lv]   <= r_cnt[sel_lv] - 1'b1;
                        r_state         <= S_QRD;
                    end else begin
                        r_state <= S_RUN;
                    end
                end
                S_QRD: begin
                    r_cand_id <= q_rdata;
                    r_state   <= S_TRD;
                end
                S_TRD: begin
                    if (!fit) begin
                        r_cnt[r_lv] <= r_cnt[r_lv] + 1'b1;
                        r_blocked   <= 1'b1;
                    end else begin
                        r_free      <= r_free - task_rdata.mem;
                        r_act       <= task_rdata;
                        r_act_valid <= 1'b1;
                        r_act_id    <= r_cand_id;
                        r_qused     <= '0;
                        r_first     <= !r_started[r_cand_id];
                        r_started[r_cand_id] <= 1'b1;
                    end
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (out_free) begin
                        r_tick        <= tick_inc;
                        r_out_valid   <= 1'b1;
                        r_time_now    <= tick_inc;
                        r_run_valid   <= r_act_valid;
                        r_run_task    <= r_act_valid ? r_act_id : '0;
                        r_first_start <= r_act_valid && r_first;
                        r_finished    <= run_fin;
                        r_turnaround  <= run_fin ? ta : '0;
                        r_waiting     <= run_fin ? ta - {16'd0, r_act.length} : '0;
                        r_demoted     <= run_dem;
                        r_blocked_o   <= r_blocked;
                        r_status      <= mlfq_pkg::ST_OK;
                        if (r_act_valid) begin
                            r_act.remaining <= rem_dec;
                            // slice restarts whenever the task leaves the processor
                            r_qused         <= (run_fin || run_dem) ? '0 : qused_inc[7:0];
                            if (run_fin) begin
                                r_free              <= gb_free;
                                r_present[r_act_id] <= 1'b0;
                                r_act_valid         <= 1'b0;
                            end else if (run_dem) begin
                                r_free        <= gb_free;
                                r_act.level   <= dem_lv;
                                r_cnt[dem_lv] <= r_cnt[dem_lv] + 1'b1;
                                r_act_valid   <= 1'b0;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_time_now    = r_time_now;
    assign o_run_valid   = r_run_valid;
    assign o_run_task    = r_run_task;
    assign o_first_start = r_first_start;
    assign o_finished    = r_finished;
    assign o_turnaround  = r_turnaround;
    assign o_waiting     = r_waiting;
    assign o_demoted     = r_demoted;
    assign o_blocked     = r_blocked_o;
    assign o_status      = r_status;

`include "mlfq_task_scheduler_core_assert.svh"

    `ASSERT_IMPL(a_free_le_cap, i_clk, i_rst_n, 1'b1, r_free <= r_cap)
    `ASSERT_IMPL(a_act_present, i_clk, i_rst_n, r_act_valid, r_present[r_act_id])
    `ASSERT_NEXT(a_acc_busy, i_clk, i_rst_n, in_acc, r_state != S_IDLE)
    `ASSERT_IMPL(a_fin_ran, i_clk, i_rst_n, o_out_valid && o_finished, o_run_valid)
    `ASSERT_IMPL(a_res_src, i_clk, i_rst_n, $rose(o_out_valid),
                 $past(r_state == S_RUN || r_state == S_ARRIVE))

endmodule

FILE: rtl/mlfq_ram.sv
// ----------------------------------------------------------------------------
// mlfq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MLFQ scheduler core. An in-bench scheduler
// model predicts one result per request; results are matched in order.
// A directed opening is followed by random phases under varied register
// settings, with random idle on the request channel and random stall on results.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [31:0] time_now;
        logic        run_valid;
        logic [5:0]  run_task;
        logic        first_start;
        logic        finished;
        logic [31:0] turnaround;
        logic [31:0] waiting;
        logic        demoted;
        logic        blocked;
        logic [1:0]  status;
    } t_sched_res;

    // scheduler model and expected-result store
    class t_sched_scoreboard;
        int unsigned levels_reg;
        int unsigned quant_reg [4];
        int unsigned capacity;
        bit [15:0]   remaining [64];
        bit [15:0]   run_len [64];
        bit [15:0]   mem_need [64];
        int unsigned level_of [64];
        bit [31:0]   arrived_at [64];
        bit          started [64];
        bit          present [64];
        bit [5:0]    lvq [4][$];
        bit          running;
        bit [5:0]    run_id;
        int unsigned slice_used;
        int unsigned free_mem;
        bit [31:0]   ticks;
        t_sched_res  expected_q [$];
        int          errors;

        function new();
            levels_reg = 4;
            quant_reg = '{2, 4, 8, 16};
            capacity = 65535;
            free_mem = 65535;
            running = 0;
            run_id = 0;
            slice_used = 0;
            ticks = 0;
            errors = 0;
            foreach (present[i]) begin
                present[i] = 0;
                started[i] = 0;
            end
        endfunction

        function void release_mem(int unsigned m);
            int unsigned f;
            f = free_mem + m;
            free_mem = (f > capacity) ? capacity : f;
        endfunction

        function int unsigned slice_of(int unsigned lv);
            int unsigned q;
            q = quant_reg[(lv < 3) ? lv : 3];
            return (q == 0) ? 1 : q;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            int unsigned held;
            case (idx)
                mlfq_pkg::CFG_LEVELS: levels_reg = data[2:0];
                mlfq_pkg::CFG_QUANT0: quant_reg[0] = data[7:0];
                mlfq_pkg::CFG_QUANT1: quant_reg[1] = data[7:0];
                mlfq_pkg::CFG_QUANT2: quant_reg[2] = data[7:0];
                mlfq_pkg::CFG_QUANT3: quant_reg[3] = data[7:0];
                mlfq_pkg::CFG_CAPACITY: begin
                    held = running ? mem_need[run_id] : 0;
                    capacity = data;
                    free_mem = (capacity > held) ? capacity - held : 0;
                end
                default: ;
            endcase
        endfunction

        // work out the result of one accepted request
        function void note_request(logic cmd, logic [5:0] id, logic [15:0] len,
                                   logic [15:0] mem);
            t_sched_res  r;
            int unsigned lv, alv, eff;
            bit          higher, first;
            bit [5:0]    cand;
            bit [31:0]   ta;
            r = '0;
            first = 0;
            if (cmd == mlfq_pkg::CMD_ARRIVE) begin
                if (present[id]) r.status = mlfq_pkg::ST_ACTIVE;
                else if (lvq[0].size() >= mlfq_pkg::MAX_TASKS) r.status = mlfq_pkg::ST_FULL;
                else begin
                    lvq[0].push_back(id);
                    if (len == 0) len = 1;
                    remaining[id] = len;
                    run_len[id] = len;
                    mem_need[id] = mem;
                    level_of[id] = 0;
                    arrived_at[id] = ticks;
                    started[id] = 0;
                    present[id] = 1;
                    r.status = mlfq_pkg::ST_OK;
                end
                r.time_now = ticks;
                expected_q.push_back(r);
                return;
            end
            // preemption by a busier higher level
            if (running) begin
                alv = level_of[run_id];
                higher = 0;
                for (lv = 0; lv < alv && lv < mlfq_pkg::MAX_LEVELS; lv++)
                    if (lvq[lv].size() != 0) higher = 1;
                if (higher) begin
                    release_mem(mem_need[run_id]);
                    lvq[alv].push_back(run_id);
                    running = 0;
                    slice_used = 0;
                end
            end
            if (!running) begin
                for (lv = 0; lv < mlfq_pkg::MAX_LEVELS; lv++) begin
                    if (lvq[lv].size() != 0) begin
                        cand = lvq[lv].pop_front();
                        if (free_mem < mem_need[cand]) begin
                            lvq[lv].push_back(cand);
                            r.blocked = 1;
                        end else begin
                            free_mem -= mem_need[cand];
                            running = 1;
                            run_id = cand;
                            slice_used = 0;
                            if (!started[cand]) begin
                                started[cand] = 1;
                                first = 1;
                            end
                        end
                        break;
                    end
                end
            end
            ticks++;
            r.time_now = ticks;
            if (running) begin
                r.run_valid = 1;
                r.run_task = run_id;
                r.first_start = first;
                remaining[run_id] = remaining[run_id] - 16'd1;
                slice_used++;
                if (remaining[run_id] == 0) begin
                    ta = ticks - arrived_at[run_id];
                    release_mem(mem_need[run_id]);
                    present[run_id] = 0;
                    running = 0;
                    slice_used = 0;
                    r.finished = 1;
                    r.turnaround = ta;
                    r.waiting = ta - 32'(run_len[run_id]);
                end else begin
                    alv = level_of[run_id];
                    if (slice_used >= slice_of(alv)) begin
                        release_mem(mem_need[run_id]);
                        eff = (levels_reg < 1) ? 1 : (levels_reg > mlfq_pkg::MAX_LEVELS) ?
                              mlfq_pkg::MAX_LEVELS : levels_reg;
                        if (alv + 1 < eff) alv++;
                        level_of[run_id] = alv;
                        lvq[alv].push_back(run_id);
                        running = 0;
                        slice_used = 0;
                        r.demoted = 1;
                    end
                end
            end
            expected_q.push_back(r);
        endfunction

        function void cmp(string name, longint unsigned e, longint unsigned a);
            if (e != a) begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_sched_res got);
            t_sched_res e;
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            cmp("time_now", e.time_now, got.time_now);
            cmp("run_valid", e.run_valid, got.run_valid);
            cmp("run_task", e.run_task, got.run_task);
            cmp("first_start", e.first_start, got.first_start);
            cmp("finished", e.finished, got.finished);
            cmp("turnaround", e.turnaround, got.turnaround);
            cmp("waiting", e.waiting, got.waiting);
            cmp("demoted", e.demoted, got.demoted);
            cmp("blocked", e.blocked, got.blocked);
            cmp("status", e.status, got.status);
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic        i_cmd = mlfq_pkg::CMD_TICK;
    logic [5:0]  i_task_id = '0;
    logic [15:0] i_run_length = '0;
    logic [15:0] i_memory_need = '0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    logic [31:0] o_time_now;
    logic        o_run_valid;
    logic [5:0]  o_run_task;
    logic        o_first_start;
    logic        o_finished;
    logic [31:0] o_turnaround;
    logic [31:0] o_waiting;
    logic        o_demoted;
    logic        o_blocked;
    logic [1:0]  o_status;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    mlfq_task_scheduler_core DUT (.*);

    t_sched_scoreboard sb = new();
    int cycles = 0;
    int results_seen = 0;
    int unsigned mem_hi = 15;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // run-away guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random stall, one long hold-off to back the core up
    initial begin : result_side
        int  stall_left;
        int  pick;
        bit  held_once;
        stall_left = 0;
        held_once = 0;
        forever begin
            @(negedge i_clk);
            if (!held_once && results_seen >= 500) begin
                held_once = 1;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1;
            end else if ((cycles / 256) % 4 == 3) begin
                i_out_stall <= 0;           // quiet stretch
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 65) i_out_stall <= 0;
                else begin
                    i_out_stall <= 1;
                    stall_left = (pick < 95) ? $urandom_range(0, 2) :
                                               $urandom_range(10, 40);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result('{o_time_now, o_run_valid, o_run_task, o_first_start,
                              o_finished, o_turnaround, o_waiting, o_demoted,
                              o_blocked, o_status});
            results_seen++;
        end
    end

    // offer one request and hold it until taken
    task automatic send_req(logic cmd, logic [5:0] id, logic [15:0] len,
                            logic [15:0] mem);
        @(negedge i_clk);
        i_in_valid <= 1;
        i_cmd <= cmd;
        i_task_id <= id;
        i_run_length <= len;
        i_memory_need <= mem;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        sb.note_request(cmd, id, len, mem);
    endtask

    task automatic idle_gap();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 50) return;
        n = (pick < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        @(negedge i_clk);
        i_in_valid <= 0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_phase(int unsigned lv, int unsigned q0, int unsigned q1,
                             int unsigned q2, int unsigned q3, int unsigned cap);
        write_reg(mlfq_pkg::CFG_LEVELS, 16'(lv));
        write_reg(mlfq_pkg::CFG_QUANT0, 16'(q0));
        write_reg(mlfq_pkg::CFG_QUANT1, 16'(q1));
        write_reg(mlfq_pkg::CFG_QUANT2, 16'(q2));
        write_reg(mlfq_pkg::CFG_QUANT3, 16'(q3));
        write_reg(mlfq_pkg::CFG_CAPACITY, 16'(cap));
        @(negedge i_clk);
        i_cfg_we <= 0;
        mem_hi = (cap / 3 > 15) ? cap / 3 : 15;
    endtask

    // random request mix: mostly short tasks with modest memory
    task automatic random_req();
        logic [15:0] len;
        logic [15:0] mem;
        int          pick;
        pick = $urandom_range(0, 99);
        len = ($urandom_range(0, 99) < 3) ? 16'($urandom) : 16'($urandom_range(0, 8));
        mem = ($urandom_range(0, 99) < 5) ? 16'($urandom) : 16'($urandom_range(0, mem_hi));
        if (pick < 40) send_req(mlfq_pkg::CMD_ARRIVE, 6'($urandom), len, mem);
        else send_req(mlfq_pkg::CMD_TICK, 6'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial begin : stimulus
        int ph;
        int k;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed opening
        send_req(mlfq_pkg::CMD_ARRIVE, 6'd0, 16'd0, 16'd0);      // zero run length
        send_req(mlfq_pkg::CMD_ARRIVE, 6'd0, 16'd3, 16'd1);      // id already queued
        send_req(mlfq_pkg::CMD_TICK, 6'd0, 16'd0, 16'd0);
        send_req(mlfq_pkg::CMD_ARRIVE, 6'd5, 16'd10, 16'd7);
        repeat (3) send_req(mlfq_pkg::CMD_TICK, 6'd0, 16'd0, 16'd0);  // demotion
        send_req(mlfq_pkg::CMD_ARRIVE, 6'd6, 16'd3, 16'd1);
        send_req(mlfq_pkg::CMD_TICK, 6'd0, 16'd0, 16'd0);        // level 1 task preempted
        send_req(mlfq_pkg::CMD_ARRIVE, 6'd6, 16'd3, 16'd1);      // id running
        repeat (4) send_req(mlfq_pkg::CMD_TICK, 6'h3f, 16'hffff, 16'hffff);
        send_req(mlfq_pkg::CMD_ARRIVE, 6'd63, 16'hffff, 16'hffff); // whole pool
        send_req(mlfq_pkg::CMD_ARRIVE, 6'd62, 16'd2, 16'd1);
        repeat (6) send_req(mlfq_pkg::CMD_TICK, 6'd0, 16'd0, 16'd0);
        drain();

        // random phases, extremes of each register among them
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_phase(4, 2, 4, 8, 16, 65535);
                1: set_phase(1, 1, 255, 1, 1, 100);
                2: set_phase(0, 255, 3, 2, 1, 0);
                3: set_phase(7, 0, 0, 0, 0, 1000);
                4: set_phase(2, 3, 255, 5, 7, 40000);
                default: set_phase(3, 1, 2, 1, 255, 65535);
            endcase
            for (k = 0; k < 215; k++) begin
                random_req();
                idle_gap();
            end
            drain();                         // sender waits for every result
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
